/* design/mfpgd_pkg.sv */
package mfpgd_pkg;

    typedef struct packed {
        logic        flaga_bit;
        logic [7:0]  flagb_byte;
        logic        flagb_present;
        logic [15:0] pixel_word0;
        logic [15:0] pixel_word1;
        logic [1:0]  pixel_words_avail;
    } in_word_t;

    typedef struct packed {
        logic [31:0] group_data;
        logic [1:0]  pixel_words_used;
        logic [1:0]  status;
        logic        last_group;
    } out_word_t;

    // Per-group control carried from the front to the back.
    typedef struct packed {
        logic [1:0] status;
        logic       last;
        logic [1:0] used;
        logic [1:0] is_pix;
    } grp_ctrl_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    localparam int HIST_ROWS = 17;

    // Copy offsets per nibble code: horizontal in byte pairs, vertical in rows.
    localparam logic [2:0] BACK_DX [16] = '{
        3'd0, 3'd1, 3'd2, 3'd4, 3'd0, 3'd1, 3'd0, 3'd1,
        3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0
    };
    localparam logic [4:0] BACK_DY [16] = '{
        5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2,
        5'd2, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd16
    };

endpackage

/* design/mfpgd_front.sv */
module mfpgd_front #(
    parameter int MAX_ROW_BYTES = 1024,
    localparam int MAX_GROUPS   = MAX_ROW_BYTES / 4,
    localparam int GW           = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    localparam int PAIRS        = MAX_ROW_BYTES / 2,
    localparam int AW           = $clog2(mfpgd_pkg::HIST_ROWS * PAIRS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic [GW:0]           gpr_eff,
    input  logic [16:0]           rows_eff,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mfpgd_pkg::in_word_t   in_word,
    input  logic                  q_full,
    output logic                  q_push,
    output mfpgd_pkg::grp_ctrl_t  q_ctrl,
    output logic [1:0][15:0]      q_pix,
    output logic [1:0][AW-1:0]    q_rd,
    output logic [AW-1:0]         q_wr
);

    localparam int PW_L = $clog2(PAIRS);

    // Position counters for the next item to be accepted.
    logic [GW-1:0] g_reg, g_next;
    logic [15:0]   row_reg, row_next;
    logic [4:0]    slot_reg, slot_next;

    logic          acc, a_move, last_col, last_row;

    // Stage A: accepted item, flag row read in flight.
    logic                a_valid_reg;
    mfpgd_pkg::in_word_t a_item_reg;
    logic [GW-1:0]       a_g_reg;
    logic [15:0]         a_row_reg;
    logic [4:0]          a_slot_reg;
    logic                a_last_reg;
    logic [7:0]          a_mem_reg;
    logic                a_vbit_reg;
    logic                a_ovr_reg;
    logic [7:0]          a_ovr_val_reg;
    logic [7:0]          a_old;

    // Stage B: classification.
    logic                b_valid_reg;
    mfpgd_pkg::in_word_t b_item_reg;
    logic [GW-1:0]       b_g_reg;
    logic [15:0]         b_row_reg;
    logic [4:0]          b_slot_reg;
    logic                b_last_reg;
    logic [7:0]          b_old_reg, b_old_next;

    logic [1:0]          sticky_reg;
    logic [7:0]          flag_mem [MAX_GROUPS];
    logic [MAX_GROUPS-1:0] vbit_reg;

    logic                b_wr, b_restart, b_ok;
    logic [7:0]          b_flag;
    logic [1:0]          status;
    logic [1:0]          avail;
    logic [1:0]          pix;
    logic [3:0]          code [2];
    logic [GW:0]         dst [2];
    logic                fmt [2];
    logic                trunc0, trunc1, ftrunc;
    logic [5:0]          src_slot [2];
    logic [PW_L-1:0]     src_idx [2];

    assign b_wr      = q_push && (sticky_reg == mfpgd_pkg::ST_OK) && !ftrunc;
    assign b_restart = q_push && b_ok && b_last_reg;

    assign q_push   = b_valid_reg && !q_full;
    assign a_move   = a_valid_reg && (!b_valid_reg || q_push);
    assign in_stall = a_valid_reg && !a_move;
    assign acc      = in_valid && !in_stall;

    assign last_col = ({1'b0, g_reg} + (GW+1)'(1)) >= gpr_eff;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= rows_eff;

    always_comb
    begin
        g_next    = g_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (acc)
        begin
            if (last_col && last_row)
            begin
                g_next    = '0;
                row_next  = '0;
                slot_next = '0;
            end
            else if (last_col)
            begin
                g_next    = '0;
                row_next  = row_reg + 16'd1;
                slot_next = (slot_reg == 5'(mfpgd_pkg::HIST_ROWS - 1)) ? 5'd0 : slot_reg + 5'd1;
            end
            else
            begin
                g_next = g_reg + GW'(1);
            end
        end
    end

    assign a_old = a_ovr_reg ? a_ovr_val_reg : (a_vbit_reg ? a_mem_reg : 8'd0);

    // An item moving into B misses the write of the item that B retires
    // at the same edge, so that write is forwarded here.
    always_comb
    begin
        if (b_restart)
            b_old_next = 8'd0;
        else if (b_wr && (b_g_reg == a_g_reg))
            b_old_next = b_flag;
        else
            b_old_next = a_old;
    end

    // Classification of the group in stage B.
    always_comb
    begin
        ftrunc = b_item_reg.flaga_bit && !b_item_reg.flagb_present;
        b_flag = b_old_reg ^ (b_item_reg.flaga_bit ? b_item_reg.flagb_byte : 8'd0);
        avail  = (b_item_reg.pixel_words_avail == 2'd3) ? 2'd2 : b_item_reg.pixel_words_avail;
        code[0] = b_flag[7:4];
        code[1] = b_flag[3:0];
        for (int h = 0; h < 2; h++)
        begin
            dst[h] = {b_g_reg, 1'(h)};
            pix[h] = (code[h] == 4'd0);
            fmt[h] = !pix[h] && ((row_reg_ext(b_row_reg) < 17'(mfpgd_pkg::BACK_DY[code[h]]))
                                 || (32'(dst[h]) < 32'(mfpgd_pkg::BACK_DX[code[h]])));
            if ({1'b0, b_slot_reg} >= 6'(mfpgd_pkg::BACK_DY[code[h]]))
                src_slot[h] = {1'b0, b_slot_reg} - 6'(mfpgd_pkg::BACK_DY[code[h]]);
            else
                src_slot[h] = {1'b0, b_slot_reg} + 6'(mfpgd_pkg::HIST_ROWS)
                              - 6'(mfpgd_pkg::BACK_DY[code[h]]);
            src_idx[h] = PW_L'(32'(dst[h]) - 32'(mfpgd_pkg::BACK_DX[code[h]]));
            q_rd[h]    = AW'(32'(src_slot[h]) * PAIRS + 32'(src_idx[h]));
        end
        trunc0 = pix[0] && (avail == 2'd0);
        trunc1 = pix[1] && ({1'b0, avail} <= ({2'b0, pix[0]}));

        priority if (sticky_reg != mfpgd_pkg::ST_OK) status = sticky_reg;
        else if (ftrunc)  status = mfpgd_pkg::ST_TRUNC;
        else if (trunc0)  status = mfpgd_pkg::ST_TRUNC;
        else if (fmt[0])  status = mfpgd_pkg::ST_FORMAT;
        else if (trunc1)  status = mfpgd_pkg::ST_TRUNC;
        else if (fmt[1])  status = mfpgd_pkg::ST_FORMAT;
        else              status = mfpgd_pkg::ST_OK;

        b_ok = (status == mfpgd_pkg::ST_OK);

        q_ctrl.status = status;
        q_ctrl.last   = b_ok && b_last_reg;
        q_ctrl.used   = b_ok ? ({1'b0, pix[0]} + {1'b0, pix[1]}) : 2'd0;
        q_ctrl.is_pix = pix;
        q_pix[0] = b_item_reg.pixel_word0;
        q_pix[1] = pix[0] ? b_item_reg.pixel_word1 : b_item_reg.pixel_word0;
        q_wr     = AW'(32'(b_slot_reg) * PAIRS + 32'(dst[0]));
    end

    function automatic logic [16:0] row_reg_ext(input logic [15:0] r);
        return {1'b0, r};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg       <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sticky_reg  <= mfpgd_pkg::ST_OK;
            vbit_reg    <= '0;
        end
        else if (restart)
        begin
            g_reg       <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sticky_reg  <= mfpgd_pkg::ST_OK;
            vbit_reg    <= '0;
        end
        else
        begin
            g_reg    <= g_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            if (acc)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;
            if (a_move)
                b_valid_reg <= 1'b1;
            else if (q_push)
                b_valid_reg <= 1'b0;
            if (q_push && (sticky_reg == mfpgd_pkg::ST_OK) && !b_ok)
                sticky_reg <= status;
            if (b_restart)
                vbit_reg <= '0;
            else if (b_wr)
                vbit_reg[b_g_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_item_reg    <= in_word;
            a_g_reg       <= g_reg;
            a_row_reg     <= row_reg;
            a_slot_reg    <= slot_reg;
            a_last_reg    <= last_col && last_row;
            a_vbit_reg    <= vbit_reg[g_reg];
            a_ovr_reg     <= b_restart || (b_wr && (b_g_reg == g_reg));
            a_ovr_val_reg <= b_restart ? 8'd0 : b_flag;
        end
        if (a_move)
        begin
            b_item_reg <= a_item_reg;
            b_g_reg    <= a_g_reg;
            b_row_reg  <= a_row_reg;
            b_slot_reg <= a_slot_reg;
            b_last_reg <= a_last_reg;
            b_old_reg  <= b_old_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            a_mem_reg <= flag_mem[g_reg];
        if (b_wr)
            flag_mem[b_g_reg] <= b_flag;
    end

`ifndef SYNTH
    a_sticky_code: assert property (@(posedge clk) disable iff (!rst_n)
        sticky_reg != 2'd3)
        else $error("sticky error holds an undefined code");
    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sticky_reg != mfpgd_pkg::ST_OK) && !restart |=> $stable(sticky_reg))
        else $error("sticky error changed without a restart");
`endif

endmodule

/* design/mfpgd_queue.sv */
module mfpgd_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] head
);

    localparam int DEPTH = 4;
    localparam int IW    = $clog2(DEPTH);

    logic [W-1:0]  data_reg [DEPTH];
    logic [IW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [IW:0]   count_reg;

    assign full      = (count_reg == (IW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + IW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + IW'(1);
            if (push && !pop)
                count_reg <= count_reg + (IW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (IW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");
`endif

endmodule

/* design/mfpgd_back.sv */
module mfpgd_back #(
    parameter int MAX_ROW_BYTES = 1024,
    localparam int PAIRS        = MAX_ROW_BYTES / 2,
    localparam int HIST_DEPTH   = mfpgd_pkg::HIST_ROWS * PAIRS,
    localparam int AW           = $clog2(HIST_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  mfpgd_pkg::grp_ctrl_t  q_ctrl,
    input  logic [1:0][15:0]      q_pix,
    input  logic [1:0][AW-1:0]    q_rd,
    input  logic [AW-1:0]         q_wr,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mfpgd_pkg::out_word_t  out_word
);

    logic [15:0] hist_mem [HIST_DEPTH];
    logic [15:0] rdata_reg;

    logic                 half_reg;
    logic                 s1_valid_reg;
    logic                 s1_half_reg;
    logic                 s1_pix_reg;
    logic [15:0]          s1_word_reg;
    logic [AW-1:0]        s1_wr_reg;
    logic                 s1_wen_reg;
    logic                 s1_fwd_reg;
    logic [15:0]          s1_fwd_val_reg;
    mfpgd_pkg::grp_ctrl_t s1_ctrl_reg;
    logic [15:0]          hi_reg;

    logic                 out_valid_reg;
    mfpgd_pkg::out_word_t out_word_reg;

    logic          advance, issue, load_out;
    logic [15:0]   s1_pair;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          h_pix;

    assign advance  = !(s1_valid_reg && s1_half_reg && out_valid_reg && out_stall);
    assign issue    = advance && q_valid;
    assign q_pop    = issue && half_reg;
    assign load_out = advance && s1_valid_reg && s1_half_reg;

    assign rd_addr = q_rd[half_reg];
    assign wr_addr = q_wr + AW'(half_reg);
    assign h_pix   = q_ctrl.is_pix[half_reg];

    // The pair written by the half in S1 lands at the same edge as the next
    // read, so a matching address takes the written value instead.
    assign s1_pair = s1_pix_reg ? s1_word_reg : (s1_fwd_reg ? s1_fwd_val_reg : rdata_reg);

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                s1_valid_reg <= issue;
            if (issue)
                half_reg <= !half_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_half_reg    <= half_reg;
            s1_pix_reg     <= h_pix;
            s1_word_reg    <= q_pix[half_reg];
            s1_wr_reg      <= wr_addr;
            s1_wen_reg     <= (q_ctrl.status == mfpgd_pkg::ST_OK);
            s1_ctrl_reg    <= q_ctrl;
            s1_fwd_reg     <= s1_valid_reg && s1_wen_reg && (s1_wr_reg == rd_addr);
            s1_fwd_val_reg <= s1_pair;
        end
        if (advance && s1_valid_reg && !s1_half_reg)
            hi_reg <= s1_pair;
        if (load_out)
        begin
            out_word_reg.group_data       <= s1_wen_reg ? {hi_reg, s1_pair} : 32'd0;
            out_word_reg.pixel_words_used <= s1_ctrl_reg.used;
            out_word_reg.status           <= s1_ctrl_reg.status;
            out_word_reg.last_group       <= s1_ctrl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && !h_pix)
            rdata_reg <= hist_mem[rd_addr];
        if (advance && s1_valid_reg && s1_wen_reg)
            hist_mem[s1_wr_reg] <= s1_pair;
    end

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_word_reg.status != mfpgd_pkg::ST_OK)
        |-> (out_word_reg.group_data == 32'd0) && !out_word_reg.last_group)
        else $error("error word carries data");
`endif

endmodule

/* design/mag_flag_pixel_group_decoder_core.sv */
// Decodes one four-byte group of a MAG packed image per input word: the flag-B
// byte is folded into the column's flag, and each nibble either takes the next
// pixel word or copies a byte pair from up to sixteen rows back. A front part
// classifies groups (flag row, error checks, addresses), a four-entry queue
// decouples it from the back part, which reads and writes the pair history.
// The history memory's single read port serves one byte pair per cycle unless
// the output stalls, so each group's two pairs are read in turn. Errors are
// sticky until reset or any register write, which also restarts the image.
// No clearing pass is needed after reset.
module mag_flag_pixel_group_decoder_core #(
    parameter int MAX_ROW_BYTES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mfpgd_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mfpgd_pkg::out_word_t out_word
);

    localparam int MAX_GROUPS = MAX_ROW_BYTES / 4;
    localparam int GW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int PAIRS      = MAX_ROW_BYTES / 2;
    localparam int AW         = $clog2(mfpgd_pkg::HIST_ROWS * PAIRS);
    localparam int CW         = $bits(mfpgd_pkg::grp_ctrl_t);
    localparam int QW         = CW + 32 + 3 * AW;

    logic [8:0]  gpr_cfg_reg;
    logic [16:0] rows_cfg_reg;
    logic        cfg_wr;
    logic [GW:0] gpr_eff;
    logic [16:0] rows_eff;

    logic                 q_full, q_push, q_pop, q_not_empty;
    mfpgd_pkg::grp_ctrl_t f_ctrl, b_ctrl;
    logic [1:0][15:0]     f_pix, b_pix;
    logic [1:0][AW-1:0]   f_rd, b_rd;
    logic [AW-1:0]        f_wr, b_wr;
    logic [QW-1:0]        q_in, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {15'd0, rows_cfg_reg} : {23'd0, gpr_cfg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_cfg_reg  <= 9'd1;
            rows_cfg_reg <= 17'd1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                rows_cfg_reg <= pwdata[16:0];
            else
                gpr_cfg_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        if (gpr_cfg_reg == 9'd0)
            gpr_eff = (GW+1)'(1);
        else if (32'(gpr_cfg_reg) > MAX_GROUPS)
            gpr_eff = (GW+1)'(MAX_GROUPS);
        else
            gpr_eff = (GW+1)'(gpr_cfg_reg);
        if (rows_cfg_reg == 17'd0)
            rows_eff = 17'd1;
        else if (rows_cfg_reg > 17'd65536)
            rows_eff = 17'd65536;
        else
            rows_eff = rows_cfg_reg;
    end

    mfpgd_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_wr),
        .gpr_eff (gpr_eff),
        .rows_eff(rows_eff),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word (in_word),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_ctrl  (f_ctrl),
        .q_pix   (f_pix),
        .q_rd    (f_rd),
        .q_wr    (f_wr)
    );

    assign q_in = {f_ctrl, f_pix, f_rd, f_wr};
    assign {b_ctrl, b_pix, b_rd, b_wr} = q_head;

    mfpgd_queue #(
        .W(QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    mfpgd_back #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_pop    (q_pop),
        .q_ctrl   (b_ctrl),
        .q_pix    (b_pix),
        .q_rd     (b_rd),
        .q_wr     (b_wr),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

endmodule
